// ===== rtl/drq_pkg.sv =====
// ----------------------------------------------------------------------------
// drq_pkg
// Shared sizes, result kinds and types of the deduplicating request queue.
// ----------------------------------------------------------------------------
package drq_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int DRAIN_BURST = 4;

   localparam int CODE_W  = 21;
   localparam int SIZE_W  = 16;
   localparam int KIND_W  = 3;
   localparam int PEND_W  = 9;
   localparam int IDX_W   = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int BURST_W = $clog2(DRAIN_BURST + 1);

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   localparam logic [KIND_W-1:0] KIND_QUEUED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CACHED     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DUPLICATE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FULL       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_POPPED     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TICK_EMPTY = 3'd5;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic             shift;
      logic             load;
      logic [IDX_W-1:0] load_sel;
      entry_type        load_data;
   } ring_ctrl_type;

endpackage

// ===== rtl/drq_req_if.sv =====
// ----------------------------------------------------------------------------
// drq_req_if
// Request channel: enqueue requests and drain ticks, one per beat.
// ----------------------------------------------------------------------------
interface drq_req_if;

   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [drq_pkg::CODE_W-1:0]  code_point;
   logic [drq_pkg::SIZE_W-1:0]  pixel_size;
   logic                        already_cached;

   modport source (
      output valid, func, code_point, pixel_size, already_cached,
      input  ready
   );

   modport sink (
      input  valid, func, code_point, pixel_size, already_cached,
      output ready
   );

endinterface

// ===== rtl/drq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// drq_rsp_if
// Response channel: one status or popped entry per beat.
// ----------------------------------------------------------------------------
interface drq_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [drq_pkg::KIND_W-1:0]  kind;
   logic [drq_pkg::CODE_W-1:0]  out_code_point;
   logic [drq_pkg::SIZE_W-1:0]  out_pixel_size;
   logic [drq_pkg::PEND_W-1:0]  pending;
   logic                        last;

   modport source (
      output valid, kind, out_code_point, out_pixel_size, pending, last,
      input  ready
   );

   modport sink (
      input  valid, kind, out_code_point, out_pixel_size, pending, last,
      output ready
   );

endinterface

// ===== rtl/drq_cell.sv =====
// ----------------------------------------------------------------------------
// drq_cell
// One queue slot: load a new entry or take the neighbour's entry on shift.
// ----------------------------------------------------------------------------
module drq_cell (
   input  logic               clock,
   input  logic               shift,
   input  logic               load,
   input  drq_pkg::entry_type load_data,
   input  drq_pkg::entry_type shift_in,
   output drq_pkg::entry_type entry
);
   import drq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = load_data;
      end else if (shift) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/drq_ring.sv =====
// ----------------------------------------------------------------------------
// drq_ring
// Closed ring of queue cells; cell zero always presents the entry under scan
// or the head of the queue. Shift rotates the ring by one place.
// ----------------------------------------------------------------------------
module drq_ring (
   input  logic                   clock,
   input  drq_pkg::ring_ctrl_type ctrl,
   output drq_pkg::entry_type     head
);
   import drq_pkg::*;

   entry_type cell_q [QUEUE_DEPTH];

   for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
      logic cell_load;

      assign cell_load = ctrl.load && (ctrl.load_sel == IDX_W'(j));

      drq_cell u_cell (
         .clock     (clock),
         .shift     (ctrl.shift),
         .load      (cell_load),
         .load_data (ctrl.load_data),
         .shift_in  (cell_q[(j + 1) % QUEUE_DEPTH]),
         .entry     (cell_q[j])
      );
   end

   assign head = cell_q[0];

endmodule

// ===== rtl/dedup_request_queue_unit.sv =====
// ----------------------------------------------------------------------------
// dedup_request_queue_unit
// Ring queue of (code point, pixel size) requests that refuses duplicates.
// Enqueue with cache hit or empty queue: idle, then decide, then response register.
// Enqueue otherwise: scan rotates the ring once round, one place per scan step,
// then decide. Drain tick: pops up to DRAIN_BURST entries, one per response,
// waiting while the response side stalls. One item in flight at a time.
// Reset clears state, count and response valid; slot contents are left unset.
// ----------------------------------------------------------------------------
module dedup_request_queue_unit (
   input  logic      clock,
   input  logic      reset,
   drq_req_if.sink   req_chan,
   drq_rsp_if.source rsp_chan
);
   import drq_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_DRAIN  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic               match_ff, match_in;
   logic               cached_ff, cached_in;
   entry_type          req_ff, req_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic [PEND_W-1:0]  rsp_pend_ff, rsp_pend_in;
   logic               rsp_last_ff, rsp_last_in;

   ring_ctrl_type      ring_ctrl;
   entry_type          head;
   logic               out_free;
   logic               accept;
   logic               drain_last;

   drq_ring u_ring (
      .clock (clock),
      .ctrl  (ring_ctrl),
      .head  (head)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign drain_last     = (count_ff == CNT_W'(1)) ||
                           (burst_ff == BURST_W'(DRAIN_BURST - 1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      burst_in     = burst_ff;
      match_in     = match_ff;
      cached_in    = cached_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_last_in  = rsp_last_ff;

      ring_ctrl.shift     = 1'b0;
      ring_ctrl.load      = 1'b0;
      ring_ctrl.load_sel  = count_ff[IDX_W-1:0];
      ring_ctrl.load_data = req_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in.code = req_chan.code_point;
               req_in.size = req_chan.pixel_size;
               cached_in   = req_chan.already_cached;
               match_in    = 1'b0;
               step_in     = '0;
               burst_in    = '0;
               if (req_chan.func == FUNC_TICK) begin
                  state_in = ST_DRAIN;
               end else if (req_chan.already_cached || count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // rotate once round the ring; slot under test sits in cell zero
            ring_ctrl.shift = 1'b1;
            if ((CNT_W'(step_ff) < count_ff) && (head == req_ff)) begin
               match_in = 1'b1;
            end
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = req_ff;
               rsp_last_in  = 1'b1;
               rsp_pend_in  = PEND_W'(count_ff);
               if (cached_ff) begin
                  rsp_kind_in = KIND_CACHED;
               end else if (match_ff) begin
                  rsp_kind_in = KIND_DUPLICATE;
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  rsp_kind_in = KIND_FULL;
               end else begin
                  rsp_kind_in    = KIND_QUEUED;
                  ring_ctrl.load = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
                  rsp_pend_in    = PEND_W'(count_ff + CNT_W'(1));
               end
               state_in = ST_IDLE;
            end
         end

         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_kind_in  = KIND_TICK_EMPTY;
                  rsp_entry_in = '0;
                  rsp_pend_in  = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  // pop the head: emit cell zero and advance the ring
                  ring_ctrl.shift = 1'b1;
                  rsp_kind_in     = KIND_POPPED;
                  rsp_entry_in    = head;
                  count_in        = count_ff - CNT_W'(1);
                  rsp_pend_in     = PEND_W'(count_ff - CNT_W'(1));
                  rsp_last_in     = drain_last;
                  burst_in        = burst_ff + BURST_W'(1);
                  if (drain_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         burst_ff     <= '0;
         match_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         burst_ff     <= burst_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cached_ff    <= cached_in;
      req_ff       <= req_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_pend_ff  <= rsp_pend_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = rsp_kind_ff;
   assign rsp_chan.out_code_point = rsp_entry_ff.code;
   assign rsp_chan.out_pixel_size = rsp_entry_ff.size;
   assign rsp_chan.pending        = rsp_pend_ff;
   assign rsp_chan.last           = rsp_last_ff;

endmodule
